/* rtl/cpim_pkg.sv */
// Package for the characteristic polynomial block: sizes, widths and
// sequencer state codes.
// No dependencies.
package cpim_pkg;

	localparam int MAX_DIM    = 8;
	localparam int ENTRY_BITS = 8;
	localparam int EB_USED    = (ENTRY_BITS < 8) ? ENTRY_BITS : 8;

	localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int AADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
	localparam int MADDR_W = AADDR_W + 1;
	localparam int ACC_W   = MAX_DIM * (EB_USED + 3) + 16;
	localparam int COEF_W  = 64;
	localparam int CIDX_W  = 4;
	localparam int DR_W    = DIM_W + 1;
	localparam int DCNT_W  = $clog2(ACC_W + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MAC   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_STEP  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

endpackage

/* rtl/char_poly_integer_matrix.sv */
// Characteristic polynomial det(xI - A) of a loaded integer matrix.
// Usage:
//   Entries are loaded one transaction each: start high while busy is low
//   stores entry_value at (row, col), one entry per cycle. A transaction with
//   last_entry set also starts the computation; busy then stays high until
//   the results are out.
//   matrix_size (write with matrix_size_we while idle) sets n; 0 acts as 1,
//   anything above 8 as 8. Reset sets n = 1.
//   Computation runs n steps of a trace recursion. Each step streams A and
//   the previous step's matrix from on-chip memories through one 8-by-104
//   multiply-accumulate, then an exact division of the trace by the step
//   number, one bit a cycle.
//   Results: n+1 transactions on consecutive cycles, coef_valid high for one
//   cycle each, x^0 first, last_coef on x^n. determinant and overflow are
//   the same on all of them. The receiver cannot stall; nothing waits.
//   Reset clears the sequencer and flags; matrix memory is undefined until
//   written.
module char_poly_integer_matrix
	import cpim_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               row,
	input  logic [2:0]               col,
	input  logic signed [7:0]        entry_value,
	input  logic                     last_entry,
	input  logic                     matrix_size_we,
	input  logic [3:0]               matrix_size,
	output logic                     coef_valid,
	output logic [CIDX_W-1:0]        coef_index,
	output logic signed [COEF_W-1:0] coef_value,
	output logic signed [COEF_W-1:0] determinant,
	output logic                     overflow,
	output logic                     last_coef
);

	logic [2:0]          state_q;
	logic [3:0]          msize_q;
	logic [DIM_W-1:0]    n_q, s_q, n_cl;
	logic [IDX_W-1:0]    i_q, j_q, k_q, nm1;
	logic                bank_q, first_step_q, ovf_q;
	logic [CIDX_W-1:0]   t_q;

	logic signed [EB_USED-1:0] amem [MAX_DIM*MAX_DIM];
	logic signed [ACC_W-1:0]   mmem [2*MAX_DIM*MAX_DIM];
	logic signed [EB_USED-1:0] a_rd_q;
	logic signed [ACC_W-1:0]   m_rd_q;
	logic [COEF_W-1:0]         coef_accum [MAX_DIM+1];

	// multiply-accumulate pipeline
	logic                      v_s1, v_s2, v_s3;
	logic                      fk_s1, fk_s2, fk_s3;
	logic                      lk_s1, lk_s2, lk_s3;
	logic                      dkj_s1, dij_s1, dij_s2, dij_s3;
	logic [AADDR_W-1:0]        wa_s1, wa_s2, wa_s3;
	logic signed [EB_USED-1:0] a_s2;
	logic signed [ACC_W-1:0]   m_s2, prod_s3;
	logic signed [ACC_W-1:0]   acc_q, acc_sum, trace_q, c_q;

	// divider
	logic [ACC_W-1:0]  mag_q;
	logic [DR_W-1:0]   rem_q, rem_sh;
	logic              neg_q, ge;
	logic [DCNT_W-1:0] dcnt_q;
	logic signed [ACC_W-1:0] c_new;
	logic              c_fits;

	logic              accept, issue, last_issue;
	logic [AADDR_W-1:0] a_raddr, a_waddr, m_off;
	logic [MADDR_W-1:0] m_raddr, m_waddr;
	logic              m_we;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign nm1    = IDX_W'(n_q - 1'b1);

	always_comb begin
		if (msize_q == 4'd0)
			n_cl = DIM_W'(1);
		else if (32'(msize_q) > MAX_DIM)
			n_cl = DIM_W'(MAX_DIM);
		else
			n_cl = DIM_W'(msize_q);
	end

	assign issue      = (state_q == ST_MAC);
	assign last_issue = issue && (i_q == nm1) && (j_q == nm1) && (k_q == nm1);
	assign a_raddr    = AADDR_W'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign m_off      = AADDR_W'(32'(k_q) * MAX_DIM + 32'(j_q));
	assign m_raddr    = {~bank_q, m_off};
	assign a_waddr    = AADDR_W'(32'(row) * MAX_DIM + 32'(col));
	assign m_waddr    = {bank_q, wa_s3};

	assign acc_sum = (fk_s3 ? '0 : acc_q) + prod_s3;
	assign m_we    = v_s3 && lk_s3;

	assign rem_sh = {rem_q[DR_W-2:0], mag_q[ACC_W-1]};
	assign ge     = (rem_sh >= DR_W'(s_q));
	assign c_new  = neg_q ? signed'(mag_q) : -signed'(mag_q);
	assign c_fits = (&c_new[ACC_W-1:COEF_W-1]) || !(|c_new[ACC_W-1:COEF_W-1]);

	// memories
	always_ff @(posedge clk) begin
		if (accept && (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM))
			amem[a_waddr] <= entry_value[EB_USED-1:0];
		a_rd_q <= amem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (m_we)
			mmem[m_waddr] <= acc_sum;
		m_rd_q <= mmem[m_raddr];
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		fk_s1  <= (k_q == '0);
		lk_s1  <= (k_q == nm1);
		dkj_s1 <= (k_q == j_q);
		dij_s1 <= (i_q == j_q);
		wa_s1  <= AADDR_W'(32'(i_q) * MAX_DIM + 32'(j_q));

		a_s2   <= a_rd_q;
		if (first_step_q)
			m_s2 <= dkj_s1 ? ACC_W'(1) : '0;
		else
			m_s2 <= m_rd_q + (dkj_s1 ? c_q : '0);
		fk_s2  <= fk_s1;
		lk_s2  <= lk_s1;
		dij_s2 <= dij_s1;
		wa_s2  <= wa_s1;

		prod_s3 <= ACC_W'(a_s2 * m_s2);
		fk_s3   <= fk_s2;
		lk_s3   <= lk_s2;
		dij_s3  <= dij_s2;
		wa_s3   <= wa_s2;

		if (v_s3)
			acc_q <= acc_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			msize_q      <= 4'd1;
			n_q          <= DIM_W'(1);
			s_q          <= DIM_W'(1);
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			bank_q       <= 1'b0;
			first_step_q <= 1'b1;
			ovf_q        <= 1'b0;
			t_q          <= '0;
			dcnt_q       <= '0;
			coef_valid   <= 1'b0;
		end else begin
			coef_valid <= 1'b0;
			if (matrix_size_we)
				msize_q <= matrix_size;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && last_entry) begin
						n_q          <= n_cl;
						s_q          <= DIM_W'(1);
						i_q          <= '0;
						j_q          <= '0;
						k_q          <= '0;
						first_step_q <= 1'b1;
						ovf_q        <= 1'b0;
						trace_q      <= '0;
						state_q      <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q != nm1) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (j_q != nm1) begin
							j_q <= j_q + 1'b1;
						end else begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end
					end
					if (last_issue)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						neg_q   <= trace_q[ACC_W-1];
						mag_q   <= trace_q[ACC_W-1] ? ACC_W'(-trace_q) : ACC_W'(trace_q);
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? DR_W'(rem_sh - DR_W'(s_q)) : rem_sh;
					mag_q  <= {mag_q[ACC_W-2:0], ge};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(ACC_W - 1))
						state_q <= ST_STEP;
				end
				ST_STEP: begin
					c_q <= c_new;
					coef_accum[CIDX_W'(n_q - s_q)] <= c_new[COEF_W-1:0];
					if (!c_fits)
						ovf_q <= 1'b1;
					trace_q <= '0;
					if (s_q == n_q) begin
						t_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						s_q          <= s_q + 1'b1;
						bank_q       <= ~bank_q;
						first_step_q <= 1'b0;
						i_q          <= '0;
						j_q          <= '0;
						k_q          <= '0;
						state_q      <= ST_MAC;
					end
				end
				ST_EMIT: begin
					coef_valid <= 1'b1;
					t_q        <= t_q + 1'b1;
					if (t_q == CIDX_W'(n_q))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// trace of A*M, gathered from the diagonal writes
			if (v_s3 && lk_s3 && dij_s3)
				trace_q <= trace_q + acc_sum;
			// leading coefficient is always one
			if (state_q == ST_IDLE && accept && last_entry)
				coef_accum[CIDX_W'(n_cl)] <= COEF_W'(1);
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			coef_index  <= t_q;
			coef_value  <= coef_accum[t_q];
			determinant <= n_q[0] ? -signed'(coef_accum[0]) : signed'(coef_accum[0]);
			overflow    <= ovf_q;
			last_coef   <= (t_q == CIDX_W'(n_q));
		end
	end

endmodule
